/* src/incremental_triangle_split_top_defines.svh */
// Assertion macros for the triangle split block
`ifndef INCREMENTAL_TRIANGLE_SPLIT_TOP_DEFINES_SVH
`define INCREMENTAL_TRIANGLE_SPLIT_TOP_DEFINES_SVH
// assert that a implies b on the next clock
`define ITS_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check failed");
// assert that a implies b in the same clock
`define ITS_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("check failed");
`endif

/* src/its_pkg.sv */
// Package with types and constants for the triangle split block
`timescale 1ns / 1ps
`default_nettype none
package its_pkg;
  localparam int MAX_POINTS = 256;
  localparam int MAX_TRIANGLES = 512;
  localparam int COORD_WIDTH = 16;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int TW = $clog2(MAX_TRIANGLES);

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_INSIDE = 3'd2;
  localparam logic [2:0] ST_EDGE = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic start_new;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] removed_slot;
    logic [8:0] slot;
    logic [7:0] vert_a;
    logic [7:0] vert_b;
    logic [7:0] vert_c;
    logic last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDT, S_RDTW, S_RDA, S_RDB, S_RDC, S_RDW,
    S_M1, S_M2, S_M3, S_CMB, S_DOT, S_DOTW, S_DECIDE,
    S_SHR, S_SHW, S_APP, S_DONE
  } state_t;
endpackage
`default_nettype wire

/* src/incremental_triangle_split_top.sv */
// Top level of the incremental triangle split block
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_triangle_split_top_defines.svh"
// Accepts one point per command (start high while busy low); busy stays high until the
// point is fully handled. Each result is on out_* for one cycle with out_valid; the
// receiver cannot stall, so every result must be taken when shown. One shared multiplier
// does every product in turn, and the point and triangle memories are read one word per
// cycle. After acceptance a point first has its trivial cases sorted out, then each stored
// triangle gets the three cross products and, unless the point is strictly inside, per edge
// a rejection or, when the point is within tolerance of that edge's line, the dot products.
// A split checks for a full table, shifts the later table entries down, and appends and
// reports each new triangle; a point that lies in no triangle ends with an outside result.
module incremental_triangle_split_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire its_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output its_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [9:0]         cfg_wdata
);
  localparam int PW = its_pkg::PW;
  localparam int TW = its_pkg::TW;
  localparam int CW = its_pkg::COORD_WIDTH;

  logic signed [CW-1:0] mem_x [its_pkg::MAX_POINTS];
  logic signed [CW-1:0] mem_y [its_pkg::MAX_POINTS];
  logic [3*PW-1:0] mem_t [its_pkg::MAX_TRIANGLES];

  its_pkg::state_t state_r, state_nxt;
  logic [9:0] tol_r;
  logic [PW:0] npts_r, npts_nxt;
  logic [TW:0] ntri_r, ntri_nxt;
  logic [TW-1:0] j_r, j_nxt, i_r, i_nxt;
  logic [1:0] k_r, k_nxt, cls_r, cls_nxt, ph_r, ph_nxt;
  logic isin_r, isin_nxt;
  logic signed [CW-1:0] px_r, py_r;
  logic [PW-1:0] p_r;
  logic [3*PW-1:0] tv_r;
  logic signed [CW-1:0] vx_r [3];
  logic signed [CW-1:0] vy_r [3];
  logic signed [CW+1:0] d_rel [3][2];
  logic signed [2*CW+4:0] prod_r, acc_r, acc_nxt;
  logic signed [2*CW+4:0] cr_r [3];
  logic signed [2*CW+4:0] cr_nxt [3];
  logic [1:0] step_r, step_nxt;
  logic dok_r, dok_nxt;

  logic [PW-1:0] prd_addr;
  logic signed [CW-1:0] prd_x, prd_y;
  logic [TW-1:0] trd_addr;
  logic [3*PW-1:0] trd_q;
  logic twe;
  logic [TW-1:0] twa;
  logic [3*PW-1:0] twd;
  logic pwe;

  logic signed [CW:0] ma, mb;
  logic ov_nxt;
  its_pkg::out_item_t oi_nxt;

  always_ff @(posedge clk) begin
    if (pwe) begin
      mem_x[p_r] <= px_r;
      mem_y[p_r] <= py_r;
    end
    prd_x <= mem_x[prd_addr];
    prd_y <= mem_y[prd_addr];
    if (twe) mem_t[twa] <= twd;
    trd_q <= mem_t[trd_addr];
  end

  always_ff @(posedge clk) prod_r <= (2*CW+5)'(ma * mb);

  function automatic logic near0(input logic signed [2*CW+4:0] v, input logic [9:0] t);
    logic signed [2*CW+4:0] tt;
    tt = (2*CW+5)'($signed({1'b0, t}));
    return (v <= tt) && (v >= -tt);
  endfunction

  // vertex indices of edge k endpoints
  function automatic logic [1:0] e0(input logic [1:0] k);
    return k;
  endfunction
  function automatic logic [1:0] e1(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      d_rel[v][0] = (CW+2)'(vx_r[v]) - (CW+2)'(px_r);
      d_rel[v][1] = (CW+2)'(vy_r[v]) - (CW+2)'(py_r);
    end
  end

  logic [PW-1:0] va, vb, vc;
  assign va = tv_r[3*PW-1:2*PW];
  assign vb = tv_r[2*PW-1:PW];
  assign vc = tv_r[PW-1:0];

  always_comb begin
    logic [1:0] a0, a1;
    logic [2*CW+4:0] z;
    logic in_tri, pos, neg;
    logic [2:0] ncount;
    state_nxt = state_r;
    npts_nxt = npts_r; ntri_nxt = ntri_r;
    j_nxt = j_r; i_nxt = i_r; k_nxt = k_r; cls_nxt = cls_r; ph_nxt = ph_r;
    isin_nxt = isin_r; acc_nxt = acc_r; step_nxt = step_r; dok_nxt = dok_r;
    cr_nxt = cr_r;
    prd_addr = va; trd_addr = j_r;
    twe = 1'b0; twa = i_r; twd = tv_r; pwe = 1'b0;
    ma = '0; mb = '0;
    ov_nxt = 1'b0; oi_nxt = '0; oi_nxt.last = 1'b1;
    a0 = e0(k_r); a1 = e1(k_r);
    z = '0;
    ncount = isin_r ? 3'd3 : 3'd2;
    in_tri = 1'b0; pos = 1'b0; neg = 1'b0;
    case (state_r)
      its_pkg::S_IDLE: begin
        if (start) begin
          if (in_item.start_new) begin
            npts_nxt = '0; ntri_nxt = '0;
          end
          state_nxt = its_pkg::S_DONE;
        end
      end
      its_pkg::S_DONE: begin
        // point latched; decide trivial cases
        if (npts_r >= (PW+1)'(its_pkg::MAX_POINTS)) begin
          ov_nxt = 1'b1; oi_nxt.status = its_pkg::ST_FULL;
          state_nxt = its_pkg::S_IDLE;
        end else begin
          pwe = 1'b1;
          npts_nxt = npts_r + 1'b1;
          if (npts_r < (PW+1)'(2)) begin
            ov_nxt = 1'b1; oi_nxt.status = its_pkg::ST_STORED;
            state_nxt = its_pkg::S_IDLE;
          end else if (npts_r == (PW+1)'(2)) begin
            twe = 1'b1; twa = '0;
            twd = {PW'(0), PW'(1), PW'(2)};
            ntri_nxt = (TW+1)'(1);
            ov_nxt = 1'b1; oi_nxt.status = its_pkg::ST_FIRST;
            oi_nxt.vert_b = 8'(1); oi_nxt.vert_c = 8'(2);
            state_nxt = its_pkg::S_IDLE;
          end else begin
            j_nxt = '0;
            state_nxt = its_pkg::S_RDT;
          end
        end
      end
      its_pkg::S_RDT: begin
        if ((TW+1)'(j_r) >= ntri_r || (ntri_r == (TW+1)'(its_pkg::MAX_TRIANGLES)
            && j_r == '0 && ph_r == 2'd1)) begin
          ov_nxt = 1'b1; oi_nxt.status = its_pkg::ST_OUTSIDE;
          ph_nxt = 2'd0;
          state_nxt = its_pkg::S_IDLE;
        end else begin
          trd_addr = j_r;
          state_nxt = its_pkg::S_RDTW;
        end
      end
      its_pkg::S_RDTW: state_nxt = its_pkg::S_RDA;
      its_pkg::S_RDA: begin prd_addr = va; state_nxt = its_pkg::S_RDB; end
      its_pkg::S_RDB: begin prd_addr = vb; state_nxt = its_pkg::S_RDC; end
      its_pkg::S_RDC: begin prd_addr = vc; state_nxt = its_pkg::S_RDW; end
      its_pkg::S_RDW: begin
        k_nxt = '0; step_nxt = '0; state_nxt = its_pkg::S_M1;
      end
      // cross k = (a-p)x*(b-a)y - (b-a)x*(a-p)y, two products per edge
      its_pkg::S_M1: begin
        ma = (CW+1)'(d_rel[a0][0]);
        mb = (CW+1)'(vy_r[a1]) - (CW+1)'(vy_r[a0]);
        state_nxt = its_pkg::S_M2;
      end
      its_pkg::S_M2: begin
        ma = (CW+1)'(vx_r[a1]) - (CW+1)'(vx_r[a0]);
        mb = (CW+1)'(d_rel[a0][1]);
        acc_nxt = prod_r;
        state_nxt = its_pkg::S_M3;
      end
      its_pkg::S_M3: begin
        cr_nxt[k_r] = acc_r - prod_r;
        if (k_r == 2'd2) state_nxt = its_pkg::S_CMB;
        else begin
          k_nxt = k_r + 1'b1; state_nxt = its_pkg::S_M1;
        end
      end
      its_pkg::S_CMB: begin
        pos = cr_r[0] > 0 && cr_r[1] > 0 && cr_r[2] > 0;
        neg = cr_r[0] < 0 && cr_r[1] < 0 && cr_r[2] < 0;
        in_tri = !near0(cr_r[0], tol_r) && !near0(cr_r[1], tol_r)
                 && !near0(cr_r[2], tol_r) && (pos || neg);
        k_nxt = '0; step_nxt = '0; dok_nxt = 1'b1;
        if (in_tri) begin
          isin_nxt = 1'b1; state_nxt = its_pkg::S_DECIDE;
        end else begin
          isin_nxt = 1'b0; state_nxt = its_pkg::S_DOT;
        end
      end
      // dot products for edge k: steps 0..3 feed d1 then d2 terms
      its_pkg::S_DOT: begin
        if (!near0(cr_r[k_r], tol_r)) begin
          state_nxt = its_pkg::S_DOTW; step_nxt = 2'd3; dok_nxt = 1'b0;
        end else begin
          case (step_r)
            2'd0: begin
              ma = -(CW+1)'(d_rel[a0][0]);
              mb = (CW+1)'(vx_r[a1]) - (CW+1)'(vx_r[a0]);
            end
            2'd1: begin
              ma = -(CW+1)'(d_rel[a0][1]);
              mb = (CW+1)'(vy_r[a1]) - (CW+1)'(vy_r[a0]);
            end
            2'd2: begin
              ma = -(CW+1)'(d_rel[a1][0]);
              mb = (CW+1)'(vx_r[a0]) - (CW+1)'(vx_r[a1]);
            end
            default: begin
              ma = -(CW+1)'(d_rel[a1][1]);
              mb = (CW+1)'(vy_r[a0]) - (CW+1)'(vy_r[a1]);
            end
          endcase
          state_nxt = its_pkg::S_DOTW;
        end
      end
      its_pkg::S_DOTW: begin
        if (dok_r) begin
          if (step_r == 2'd0 || step_r == 2'd2) acc_nxt = prod_r;
          else begin
            if (acc_r + prod_r < 0) dok_nxt = 1'b0;
          end
        end
        if (step_r == 2'd3) begin
          if (dok_nxt) begin
            cls_nxt = k_r; state_nxt = its_pkg::S_DECIDE;
          end else if (k_r == 2'd2) begin
            j_nxt = j_r + 1'b1; state_nxt = its_pkg::S_RDT;
            if (j_r == TW'(its_pkg::MAX_TRIANGLES - 1)) ph_nxt = 2'd1;
          end else begin
            k_nxt = k_r + 1'b1; step_nxt = '0; dok_nxt = 1'b1;
            state_nxt = its_pkg::S_DOT;
          end
        end else begin
          step_nxt = step_r + 1'b1; state_nxt = its_pkg::S_DOT;
        end
      end
      its_pkg::S_DECIDE: begin
        if (ntri_r - 1'b1 + (TW+1)'(ncount) > (TW+1)'(its_pkg::MAX_TRIANGLES)) begin
          ov_nxt = 1'b1; oi_nxt.status = its_pkg::ST_FULL;
          state_nxt = its_pkg::S_IDLE;
        end else begin
          i_nxt = j_r; state_nxt = its_pkg::S_SHR;
        end
      end
      its_pkg::S_SHR: begin
        if ((TW+1)'(i_r) + 1'b1 >= ntri_r) begin
          ntri_nxt = ntri_r - 1'b1; k_nxt = '0; state_nxt = its_pkg::S_APP;
        end else begin
          trd_addr = i_r + 1'b1; state_nxt = its_pkg::S_SHW;
        end
      end
      its_pkg::S_SHW: begin
        twe = 1'b1; twa = i_r; twd = trd_q;
        i_nxt = i_r + 1'b1; state_nxt = its_pkg::S_SHR;
      end
      its_pkg::S_APP: begin
        twe = 1'b1; twa = TW'(ntri_r);
        if (isin_r) begin
          case (k_r)
            2'd0: twd = {va, vb, p_r};
            2'd1: twd = {vb, vc, p_r};
            default: twd = {va, vc, p_r};
          endcase
        end else begin
          case ({cls_r, k_r[0]})
            3'b000: twd = {va, vc, p_r};
            3'b001: twd = {vb, vc, p_r};
            3'b010: twd = {va, vc, p_r};
            3'b011: twd = {va, vb, p_r};
            3'b100: twd = {va, vb, p_r};
            default: twd = {vb, vc, p_r};
          endcase
        end
        ntri_nxt = ntri_r + 1'b1;
        ov_nxt = 1'b1;
        oi_nxt.status = isin_r ? its_pkg::ST_INSIDE : its_pkg::ST_EDGE;
        oi_nxt.removed_slot = 9'(j_r);
        oi_nxt.slot = 9'(ntri_r);
        oi_nxt.vert_a = 8'(twd[3*PW-1:2*PW]);
        oi_nxt.vert_b = 8'(twd[2*PW-1:PW]);
        oi_nxt.vert_c = 8'(twd[PW-1:0]);
        oi_nxt.last = ((3)'(k_r) + 3'd1 == ncount);
        if (oi_nxt.last) begin
          ph_nxt = 2'd0; state_nxt = its_pkg::S_IDLE;
        end else k_nxt = k_r + 1'b1;
      end
      default: state_nxt = its_pkg::S_IDLE;
    endcase
    z = acc_nxt;
    acc_nxt = z;
  end

  assign busy = (state_r != its_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= its_pkg::S_IDLE;
      npts_r <= '0; ntri_r <= '0; tol_r <= '0;
      out_valid <= 1'b0; ph_r <= '0;
    end else begin
      state_r <= state_nxt;
      npts_r <= npts_nxt; ntri_r <= ntri_nxt;
      ph_r <= ph_nxt;
      out_valid <= ov_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= oi_nxt;
    j_r <= j_nxt; i_r <= i_nxt; k_r <= k_nxt; cls_r <= cls_nxt;
    isin_r <= isin_nxt; acc_r <= acc_nxt; step_r <= step_nxt; dok_r <= dok_nxt;
    cr_r <= cr_nxt;
    if (state_r == its_pkg::S_IDLE && start) begin
      px_r <= in_item.point_x; py_r <= in_item.point_y;
      p_r <= in_item.start_new ? '0 : PW'(npts_r);
    end
    if (state_r == its_pkg::S_RDTW) tv_r <= trd_q;
    if (state_r == its_pkg::S_RDB) begin vx_r[0] <= prd_x; vy_r[0] <= prd_y; end
    if (state_r == its_pkg::S_RDC) begin vx_r[1] <= prd_x; vy_r[1] <= prd_y; end
    if (state_r == its_pkg::S_RDW) begin vx_r[2] <= prd_x; vy_r[2] <= prd_y; end
  end

  `ITS_ASSERT_NOW(a_out_last, clk, !rst_n, out_valid && out_item.last, !busy)
  `ITS_ASSERT_NEXT(a_start_busy, clk, !rst_n, start && !busy, busy)
  `ITS_ASSERT_NOW(a_ntri_max, clk, !rst_n, 1'b1, ntri_r <= (TW+1)'(its_pkg::MAX_TRIANGLES))
  `ITS_ASSERT_NOW(a_npts_max, clk, !rst_n, 1'b1, npts_r <= (PW+1)'(its_pkg::MAX_POINTS))
endmodule
`default_nettype wire

/* tb/incremental_triangle_split_top_tb.sv */
// Self-checking testbench for the incremental triangle split block
`timescale 1ns / 1ps
module incremental_triangle_split_top_tb;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  its_pkg::in_item_t in_item;
  logic out_valid;
  its_pkg::out_item_t out_item;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  incremental_triangle_split_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [15:0] pt_x [its_pkg::MAX_POINTS];
  logic signed [15:0] pt_y [its_pkg::MAX_POINTS];
  logic [7:0] tri_v [its_pkg::MAX_TRIANGLES][3];
  int unsigned npts;
  int unsigned ntris;
  longint tol;

  its_pkg::out_item_t split_q[$];
  int errors;
  int results_seen;
  int items_sent;
  int send_idle_pct;
  longint cycles;
  localparam longint CYCLE_LIMIT = 4000000;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cycle limit reached");
      $display("incremental_triangle_split_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (split_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none actual %p", $time, out_item);
      end else begin
        if (out_item !== split_q[0]) begin
          errors++;
          $display("%0t expected %p actual %p", $time, split_q[0], out_item);
        end
        void'(split_q.pop_front());
      end
    end
  end

  function automatic void expect_result(its_pkg::out_item_t r);
    split_q = {split_q, r};
  endfunction

  function automatic longint edge_cross(int i, int j, longint px, longint py);
    longint ax, ay, bx, by;
    ax = pt_x[i]; ay = pt_y[i]; bx = pt_x[j]; by = pt_y[j];
    return (ax - px) * (by - ay) - (bx - ax) * (ay - py);
  endfunction

  function automatic bit on_seg(int i, int j, longint px, longint py);
    longint ax, ay, bx, by, d1, d2;
    ax = pt_x[i]; ay = pt_y[i]; bx = pt_x[j]; by = pt_y[j];
    d1 = (px - ax) * (bx - ax) + (py - ay) * (by - ay);
    d2 = (px - bx) * (ax - bx) + (py - by) * (ay - by);
    return d1 >= 0 && d2 >= 0;
  endfunction

  function automatic bit nz(longint v);
    return v <= tol && v >= -tol;
  endfunction

  // 0 inside, 1..3 on that edge, 4 outside
  function automatic int locate(int t, longint px, longint py);
    longint c1, c2, c3;
    c1 = edge_cross(tri_v[t][0], tri_v[t][1], px, py);
    c2 = edge_cross(tri_v[t][1], tri_v[t][2], px, py);
    c3 = edge_cross(tri_v[t][2], tri_v[t][0], px, py);
    if (!nz(c1) && !nz(c2) && !nz(c3) &&
        ((c1 > 0 && c2 > 0 && c3 > 0) || (c1 < 0 && c2 < 0 && c3 < 0)))
      return 0;
    if (nz(c1) && on_seg(tri_v[t][0], tri_v[t][1], px, py)) return 1;
    if (nz(c2) && on_seg(tri_v[t][1], tri_v[t][2], px, py)) return 2;
    if (nz(c3) && on_seg(tri_v[t][2], tri_v[t][0], px, py)) return 3;
    return 4;
  endfunction

  function automatic its_pkg::out_item_t status_only(logic [2:0] st);
    its_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic insert_point(its_pkg::in_item_t it);
    longint px, py;
    int p, cls, n;
    logic [7:0] a, b, c;
    logic [7:0] nv [3][2];
    its_pkg::out_item_t r;
    px = it.point_x;
    py = it.point_y;
    if (it.start_new) begin
      npts = 0;
      ntris = 0;
    end
    if (npts >= its_pkg::MAX_POINTS) begin
      expect_result(status_only(its_pkg::ST_FULL));
      return;
    end
    p = npts;
    pt_x[p] = it.point_x;
    pt_y[p] = it.point_y;
    npts++;
    if (npts < 3) begin
      expect_result(status_only(its_pkg::ST_STORED));
      return;
    end
    if (npts == 3) begin
      tri_v[0][0] = 8'd0; tri_v[0][1] = 8'd1; tri_v[0][2] = 8'd2;
      ntris = 1;
      r = status_only(its_pkg::ST_FIRST);
      r.vert_b = 8'd1;
      r.vert_c = 8'd2;
      expect_result(r);
      return;
    end
    for (int j = 0; j < ntris; j++) begin
      cls = locate(j, px, py);
      if (cls == 4) continue;
      a = tri_v[j][0]; b = tri_v[j][1]; c = tri_v[j][2];
      n = (cls == 0) ? 3 : 2;
      if (ntris - 1 + n > its_pkg::MAX_TRIANGLES) begin
        expect_result(status_only(its_pkg::ST_FULL));
        return;
      end
      case (cls)
        0: begin
          nv[0][0] = a; nv[0][1] = b; nv[1][0] = b; nv[1][1] = c; nv[2][0] = a; nv[2][1] = c;
        end
        1: begin
          nv[0][0] = a; nv[0][1] = c; nv[1][0] = b; nv[1][1] = c;
        end
        2: begin
          nv[0][0] = a; nv[0][1] = c; nv[1][0] = a; nv[1][1] = b;
        end
        default: begin
          nv[0][0] = a; nv[0][1] = b; nv[1][0] = b; nv[1][1] = c;
        end
      endcase
      for (int i = j; i + 1 < ntris; i++) tri_v[i] = tri_v[i + 1];
      ntris--;
      for (int i = 0; i < n; i++) begin
        tri_v[ntris][0] = nv[i][0];
        tri_v[ntris][1] = nv[i][1];
        tri_v[ntris][2] = p[7:0];
        r.status = (cls == 0) ? its_pkg::ST_INSIDE : its_pkg::ST_EDGE;
        r.removed_slot = j[8:0];
        r.slot = ntris[8:0];
        r.vert_a = nv[i][0];
        r.vert_b = nv[i][1];
        r.vert_c = p[7:0];
        r.last = (i + 1 == n);
        expect_result(r);
        ntris++;
      end
      return;
    end
    expect_result(status_only(its_pkg::ST_OUTSIDE));
  endtask

  task automatic send_point(bit fresh, int x, int y);
    its_pkg::in_item_t it;
    it.start_new = fresh;
    it.point_x = x[15:0];
    it.point_y = y[15:0];
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    #1;
    while (busy) begin
      @(posedge clk);
      #1;
    end
    @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    start <= 1'b0;
    in_item <= its_pkg::in_item_t'({1'b0, $urandom});
    insert_point(it);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (split_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [9:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol = v;
  endtask

  task automatic test_basic_shapes();
    send_point(1, 0, 0);
    send_point(0, 1000, 0);
    send_point(0, 0, 1000);
    send_point(0, 100, 100);
    send_point(0, 500, 0);
    send_point(0, 0, 500);
    send_point(0, 500, 500);
    send_point(0, 5000, 5000);
    send_point(0, 1000, 0);
    send_point(0, 300, 200);
  endtask

  task automatic test_extremes();
    send_point(1, -32768, -32768);
    send_point(0, 32767, -32768);
    send_point(0, -32768, 32767);
    send_point(0, -1, -1);
    send_point(0, 0, -32768);
    send_point(0, -32768, 0);
    send_point(0, 32767, 32767);
    send_point(0, -20000, -30000);
  endtask

  task automatic test_tolerance_edges();
    send_point(1, 0, 0);
    send_point(0, 2000, 0);
    send_point(0, 0, 2000);
    send_point(0, 700, 1);
    send_point(0, 1, 800);
    send_point(0, 1001, 1000);
  endtask

  // mostly random points inside a base triangle, some near its bottom edge, some anywhere
  task automatic test_random_mesh(int count);
    int x, y;
    send_point(1, -30000, -30000);
    send_point(0, 30000, -30000);
    send_point(0, 0, 30000);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: begin
          x = $signed($urandom_range(65535) - 32768);
          y = $signed($urandom_range(65535) - 32768);
        end
        1: begin
          x = $urandom_range(20000) - 10000;
          y = -30000 + $urandom_range(3);
        end
        default: begin
          y = $urandom_range(50000) - 28000;
          x = $urandom_range(2 * (30000 - y) / 2) - (30000 - y) / 2;
        end
      endcase
      send_point($urandom_range(59) == 0, x, y);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    npts = 0;
    ntris = 0;
    tol = 0;
    send_idle_pct = 28;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_shapes();
    test_extremes();
    write_tolerance(10'd1023);
    test_tolerance_edges();
    write_tolerance(10'd0);
    test_random_mesh(29);
    write_tolerance(10'd5);
    send_idle_pct = 78;
    test_random_mesh(29);
    write_tolerance(10'd0);
    send_idle_pct = 0;
    test_random_mesh(29);
    drain();
    $display("sent %0d points, checked %0d results", items_sent, results_seen);
    $display("covered first triangle, inside and edge splits, outside points, restarts");
    $display("and tolerance 0..1023 with and without gaps between points");
    if (errors == 0 && split_q.size() == 0) begin
      $display("incremental_triangle_split_top: match");
    end else begin
      $display("incremental_triangle_split_top: mismatch");
    end
    $finish;
  end
endmodule
